// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/flm_pkg.sv -----
// Shared constants, types and helpers of the fixed-string line matcher.
`default_nettype none
package flm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int MAX_LINE    = 1024;
  localparam int POS_W       = $clog2(MAX_LINE);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 64;
  localparam int OFS_W       = 10;
  localparam int CNT_W       = 10;
  localparam int WIDE_W      = 32;
  localparam int OUT_DATA_W  = 88;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_FLUSH    = 1'b1;
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    CFG_EXCEPT = 2'd0,
    CFG_LEN    = 2'd1,
    CFG_PAT_LO = 2'd2,
    CFG_PAT_HI = 2'd3
  } cfg_reg_t;

  // One result item.
  typedef struct packed {
    logic              kind;
    logic [OFS_W-1:0]  offset;
    logic [WIDE_W-1:0] line_number;
    logic [CNT_W-1:0]  line_total;
    logic              selected;
    logic [WIDE_W-1:0] sel_total;
    logic              last;
  } res_t;

  // Results produced by the line controller in one cycle (0 to 2).
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Item sitting between the cell row and the line controller.
  typedef struct packed {
    logic valid;
    logic cmd;
    logic nl;
  } item_t;

  // Pattern byte compared in cell j: pattern is right-aligned to the newest byte.
  function automatic logic [BYTE_W-1:0] aligned_byte(
      input logic [2*PAT_W-1:0] pat,
      input logic [LEN_W-1:0]   len,
      input logic [IDX_W-1:0]   j);
    logic [LEN_W-1:0] idx;
    idx = len - LEN_W'(1) - LEN_W'(j);
    aligned_byte = pat[BYTE_W*idx[IDX_W-1:0] +: BYTE_W];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fixed_string_line_matcher_top.sv -----
// Top level of the fixed-string line matcher: cell row, line controller, output queue.
// Results of an accepted item pass the item register and cell row, then the output queue.
// Throughput: one input item per cycle unless the input stalls.
// Input stalls when the 8-entry output queue cannot take two more results beyond
// the up to two of the item in flight.
// Reset (rst_n low, synchronous): registers, counters and queue are cleared; line number is set to 1.
// The window cells hold no reset; bytes from outside the current line are masked.
`default_nettype none
module fixed_string_line_matcher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tuser,   // [0] command
  // result stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [87:0] out_tdata,  // [9:0] match_offset, [41:10] line_number,
                                       // [51:42] line_match_total, [52] line_selected,
                                       // [84:53] selected_match_total, [87:85] zero
  output      logic        out_tuser,  // [0] report_kind
  output      logic        out_tlast,  // last_of_run
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam int PM = flm_pkg::PATTERN_MAX;

  // Configuration registers
  logic                         except_r;
  logic [flm_pkg::LEN_W-1:0]    len_r;
  logic [flm_pkg::PAT_W-1:0]    pat_lo_r, pat_hi_r;
  logic [flm_pkg::LEN_W-1:0]    len_eff;
  logic [2*flm_pkg::PAT_W-1:0]  pat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      except_r <= 1'b0;
      len_r    <= '0;
      pat_lo_r <= '0;
      pat_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (flm_pkg::cfg_reg_t'(cfg_index))
        flm_pkg::CFG_EXCEPT: except_r <= cfg_wdata[0];
        flm_pkg::CFG_LEN:    len_r    <= cfg_wdata[flm_pkg::LEN_W-1:0];
        flm_pkg::CFG_PAT_LO: pat_lo_r <= cfg_wdata;
        flm_pkg::CFG_PAT_HI: pat_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Oversized lengths act as the full pattern.
  assign len_eff = (len_r > flm_pkg::LEN_W'(PM)) ? flm_pkg::LEN_W'(PM) : len_r;
  assign pat     = {pat_hi_r, pat_lo_r};

  // Input handshake; bytes shift into the cell row, flushes do not.
  logic in_acc, shift_en, room;
  flm_pkg::item_t item_r, item_nxt;

  assign in_acc   = in_tvalid && in_tready;
  assign shift_en = in_acc && (in_tuser == flm_pkg::CMD_BYTE);

  always_comb begin
    item_nxt.valid = in_acc;
    item_nxt.cmd   = in_tuser;
    item_nxt.nl    = (in_tdata == flm_pkg::NEWLINE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
    end
    item_r.cmd <= item_nxt.cmd;
    item_r.nl  <= item_nxt.nl;
  end

  // Cell row: cell 0 takes the newest byte, cell j the byte j steps back.
  logic [flm_pkg::BYTE_W-1:0] cell_byte [PM];
  logic [PM-1:0]              cell_eq;

  for (genvar j = 0; j < PM; j++) begin : g_cell
    logic [flm_pkg::BYTE_W-1:0] byte_in;
    logic                       care;
    if (j == 0) begin : g_first
      assign byte_in = in_tdata;
    end else begin : g_next
      assign byte_in = cell_byte[j-1];
    end
    assign care = (flm_pkg::LEN_W'(j) < len_eff);

    flm_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (byte_in),
      .pat_byte (flm_pkg::aligned_byte(pat, len_eff, flm_pkg::IDX_W'(j))),
      .care     (care),
      .byte_r   (cell_byte[j]),
      .eq_r     (cell_eq[j])
    );
  end

  // Line controller
  flm_pkg::push_t push;

  flm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item_r),
    .all_eq      (&cell_eq),
    .except_mode (except_r),
    .len_eff     (len_eff),
    .push        (push)
  );

  // Output queue
  flm_pkg::res_t head;
  logic          not_empty;

  flm_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pend      (item_r.valid),
    .pop       (out_tvalid && out_tready),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  assign in_tready  = room;
  assign out_tvalid = not_empty;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {3'b000, head.sel_total, head.selected, head.line_total,
                       head.line_number, head.offset};

endmodule
`default_nettype wire

// ----- rtl/flm_cell.sv -----
// One window cell: holds a text byte, passes it on and compares it to its pattern byte.
`default_nettype none
module flm_cell (
  input  wire logic                      clk,
  input  wire logic                      shift_en,
  input  wire logic [flm_pkg::BYTE_W-1:0] byte_in,
  input  wire logic [flm_pkg::BYTE_W-1:0] pat_byte,
  input  wire logic                      care,
  output      logic [flm_pkg::BYTE_W-1:0] byte_r,
  output      logic                      eq_r
);

  logic [flm_pkg::BYTE_W-1:0] byte_nxt;
  logic                      eq_nxt;

  assign byte_nxt = byte_in;
  assign eq_nxt   = !care || (byte_in == pat_byte);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_nxt;
      eq_r   <= eq_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/flm_ctrl.sv -----
// Line controller: match decision, line bookkeeping and result generation.
`default_nettype none
module flm_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire flm_pkg::item_t             item,
  input  wire logic                       all_eq,
  input  wire logic                       except_mode,
  input  wire logic [flm_pkg::LEN_W-1:0]  len_eff,
  output      flm_pkg::push_t             push
);

  localparam int CMP_W = ((flm_pkg::POS_W > flm_pkg::LEN_W) ?
                          flm_pkg::POS_W : flm_pkg::LEN_W) + 1;
  localparam logic [flm_pkg::CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [flm_pkg::WIDE_W-1:0] WIDE_MAX = '1;
  localparam logic [CMP_W-1:0] LINE_LIMIT = CMP_W'(flm_pkg::MAX_LINE - 1);

  logic [flm_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [flm_pkg::POS_W-1:0]  ens_r, ens_nxt;
  logic [flm_pkg::CNT_W-1:0]  matches_r, matches_nxt;
  logic [flm_pkg::WIDE_W-1:0] line_r, line_nxt;
  logic [flm_pkg::WIDE_W-1:0] stot_r, stot_nxt;

  logic [CMP_W-1:0]          pos1, len_x, start;
  logic                      is_byte, hit, line_end, sel;
  logic [flm_pkg::CNT_W-1:0] matches_h;
  logic [flm_pkg::WIDE_W:0]  sum;
  logic [flm_pkg::WIDE_W-1:0] stot_end;
  flm_pkg::res_t             match_res, sum_res;

  always_comb begin
    is_byte = item.valid && (item.cmd == flm_pkg::CMD_BYTE);
    pos1    = CMP_W'(pos_r) + CMP_W'(1);
    len_x   = CMP_W'(len_eff);
    start   = pos1 - len_x;
    hit     = is_byte && (len_eff != '0) && (pos1 >= len_x) &&
              (start >= CMP_W'(ens_r)) && all_eq;
    matches_h = (hit && matches_r != CNT_MAX) ? matches_r + flm_pkg::CNT_W'(1) : matches_r;
    line_end = (is_byte && (item.nl || pos1 >= LINE_LIMIT)) ||
               (item.valid && item.cmd == flm_pkg::CMD_FLUSH && pos_r != '0);
    sel      = (matches_h != '0) ^ except_mode;
    sum      = {1'b0, stot_r} + (flm_pkg::WIDE_W + 1)'(matches_h);
    stot_end = !sel ? stot_r : (sum[flm_pkg::WIDE_W] ? WIDE_MAX : sum[flm_pkg::WIDE_W-1:0]);

    match_res.kind        = flm_pkg::KIND_MATCH;
    match_res.offset      = flm_pkg::OFS_W'(start);
    match_res.line_number = line_r;
    match_res.line_total  = '0;
    match_res.selected    = 1'b0;
    match_res.sel_total   = stot_r;
    match_res.last        = !line_end;

    sum_res.kind        = flm_pkg::KIND_SUMMARY;
    sum_res.offset      = '0;
    sum_res.line_number = line_r;
    sum_res.line_total  = matches_h;
    sum_res.selected    = sel;
    sum_res.sel_total   = stot_end;
    sum_res.last        = 1'b1;

    push.n  = 2'(hit) + 2'(line_end);
    push.r0 = hit ? match_res : sum_res;
    push.r1 = sum_res;

    pos_nxt     = pos_r;
    ens_nxt     = ens_r;
    matches_nxt = matches_r;
    line_nxt    = line_r;
    stot_nxt    = stot_r;
    if (is_byte) begin
      pos_nxt     = flm_pkg::POS_W'(pos1);
      matches_nxt = matches_h;
      if (hit) begin
        ens_nxt = flm_pkg::POS_W'(pos1);
      end
    end
    if (line_end) begin
      pos_nxt     = '0;
      ens_nxt     = '0;
      matches_nxt = '0;
      stot_nxt    = stot_end;
      if (line_r != WIDE_MAX) begin
        line_nxt = line_r + flm_pkg::WIDE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ens_r     <= '0;
      matches_r <= '0;
      line_r    <= flm_pkg::WIDE_W'(1);
      stot_r    <= '0;
    end else begin
      pos_r     <= pos_nxt;
      ens_r     <= ens_nxt;
      matches_r <= matches_nxt;
      line_r    <= line_nxt;
      stot_r    <= stot_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/flm_ofifo.sv -----
// Output queue: takes up to two results a cycle, hands out one.
`default_nettype none
module flm_ofifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire flm_pkg::push_t push,
  input  wire logic           pend,
  input  wire logic           pop,
  output      logic           room,
  output      logic           not_empty,
  output      flm_pkg::res_t  head
);

  localparam int CNT_W = flm_pkg::FIFO_AW + 1;

  flm_pkg::res_t mem_r [flm_pkg::FIFO_DEPTH];
  logic [flm_pkg::FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  always_comb begin
    wp1       = wp_r + flm_pkg::FIFO_AW'(1);
    wp_nxt    = wp_r + flm_pkg::FIFO_AW'(push.n);
    rp_nxt    = pop ? rp_r + flm_pkg::FIFO_AW'(1) : rp_r;
    cnt_nxt   = cnt_r + CNT_W'(push.n) - CNT_W'(pop);
    not_empty = (cnt_r != '0);
    head      = mem_r[rp_r];
    // Reserve two slots for the item in flight and two for a new one.
    room      = (cnt_r + (pend ? CNT_W'(2) : CNT_W'(0))) <= CNT_W'(flm_pkg::FIFO_DEPTH - 2);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/flm_checker.sv -----
// Port-level checker for the line matcher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module flm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // A line summary always closes its run.
  `ASSERT_IMPLIES(a_sum_last, clk, rst_n, out_tvalid && out_tuser == flm_pkg::KIND_SUMMARY, out_tlast)
  // Match items carry no line count and are never flagged selected.
  `ASSERT_IMPLIES(a_match_flds, clk, rst_n, out_tvalid && out_tuser == flm_pkg::KIND_MATCH, out_tdata[52:42] == 11'd0)
  // Summaries carry a zero offset.
  `ASSERT_IMPLIES(a_sum_ofs, clk, rst_n, out_tvalid && out_tuser == flm_pkg::KIND_SUMMARY, out_tdata[9:0] == 10'd0)

endmodule

bind fixed_string_line_matcher_top flm_checker u_flm_checker (.*);
`default_nettype wire
